// ----- hdl/sbvc_pkg.sv -----
// ----------------------------------------------------------------------------
// sbvc_pkg
// Shared types and constants of the segment/box line-of-sight checker.
// ----------------------------------------------------------------------------
package sbvc_pkg;

	localparam int COORD_W     = 24;
	localparam int DIFF_W      = COORD_W + 1;
	localparam int PROD_W      = 2 * DIFF_W;
	localparam int CROSS_W     = PROD_W + 1;
	localparam int EDGE_WORD_W = 2 * COORD_W;
	localparam int INDEX_OUT_W = 6;
	localparam int COUNT_OUT_W = 7;

	localparam int MAX_BOXES_DEF = 64;

	localparam logic REQ_ADD   = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic signed [COORD_W-1:0] ax;
		logic signed [COORD_W-1:0] ay;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by;
		logic signed [DIFF_W-1:0]  dx;
		logic signed [DIFF_W-1:0]  dy;
		logic                      neg;
	} link_t;

	typedef struct packed {
		logic valid;
		logic last;
	} ctl_t;

endpackage

// ----- hdl/sbvc_ram.sv -----
// ----------------------------------------------------------------------------
// sbvc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sbvc_ram #(
	parameter int WIDTH = sbvc_pkg::EDGE_WORD_W,
	parameter int DEPTH = sbvc_pkg::MAX_BOXES_DEF
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/sbvc_box_eval.sv -----
// ----------------------------------------------------------------------------
// sbvc_box_eval
// Box test pipeline: edge differences, cross products, corner side vote.
// ----------------------------------------------------------------------------
module sbvc_box_eval #(
	parameter int MAX_BOXES = sbvc_pkg::MAX_BOXES_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   flush,
	input  sbvc_pkg::link_t                        link,
	input  sbvc_pkg::ctl_t                         ctl_s1,
	input  logic [((MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1)-1:0] idx_s1,
	input  logic [sbvc_pkg::EDGE_WORD_W-1:0]       x_word_s1,
	input  logic [sbvc_pkg::EDGE_WORD_W-1:0]       y_word_s1,
	output sbvc_pkg::ctl_t                         ctl_s3,
	output logic [((MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1)-1:0] idx_s3,
	output logic                                   block_s3
);

	localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CW = sbvc_pkg::COORD_W;
	localparam int DW = sbvc_pkg::DIFF_W;
	localparam int PW = sbvc_pkg::PROD_W;
	localparam int XW = sbvc_pkg::CROSS_W;

	logic signed [CW-1:0] x0, x1, y0, y1;
	logic signed [DW-1:0] dx0, dx1, dy0, dy1;
	logic                 beyond;

	sbvc_pkg::ctl_t       ctl_s2;
	logic [AW-1:0]        idx_s2;
	logic signed [DW-1:0] dx0_s2, dx1_s2, dy0_s2, dy1_s2;
	logic                 beyond_s2, beyond_s3;

	logic signed [PW-1:0] py0_s3, py1_s3, px0_s3, px1_s3;
	logic signed [XW-1:0] c00, c11, c01, c10;
	logic                 a00, a11, a01, a10;

	assign x0 = x_word_s1[CW-1:0];
	assign x1 = x_word_s1[2*CW-1:CW];
	assign y0 = y_word_s1[CW-1:0];
	assign y1 = y_word_s1[2*CW-1:CW];

	assign dx0 = {x0[CW-1], x0} - {link.ax[CW-1], link.ax};
	assign dx1 = {x1[CW-1], x1} - {link.ax[CW-1], link.ax};
	assign dy0 = {y0[CW-1], y0} - {link.ay[CW-1], link.ay};
	assign dy1 = {y1[CW-1], y1} - {link.ay[CW-1], link.ay};

	assign beyond = (link.ax > x1 && link.bx > x1) || (link.ax < x0 && link.bx < x0)
		|| (link.ay > y1 && link.by > y1) || (link.ay < y0 && link.by < y0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (flush) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2    <= idx_s1;
		dx0_s2    <= dx0;
		dx1_s2    <= dx1;
		dy0_s2    <= dy0;
		dy1_s2    <= dy1;
		beyond_s2 <= beyond;
		idx_s3    <= idx_s2;
		beyond_s3 <= beyond_s2;
		py0_s3    <= link.dx * dy0_s2;
		py1_s3    <= link.dx * dy1_s2;
		px0_s3    <= link.dy * dx0_s2;
		px1_s3    <= link.dy * dx1_s2;
	end

	assign c00 = {py0_s3[PW-1], py0_s3} - {px0_s3[PW-1], px0_s3};
	assign c11 = {py1_s3[PW-1], py1_s3} - {px1_s3[PW-1], px1_s3};
	assign c01 = {py1_s3[PW-1], py1_s3} - {px0_s3[PW-1], px0_s3};
	assign c10 = {py0_s3[PW-1], py0_s3} - {px1_s3[PW-1], px1_s3};

	assign a00 = link.neg ? c00[XW-1] : (!c00[XW-1] && c00 != '0);
	assign a11 = link.neg ? c11[XW-1] : (!c11[XW-1] && c11 != '0);
	assign a01 = link.neg ? c01[XW-1] : (!c01[XW-1] && c01 != '0);
	assign a10 = link.neg ? c10[XW-1] : (!c10[XW-1] && c10 != '0);

	assign block_s3 = !((a00 && a11 && a01 && a10) || !(a00 || a11 || a01 || a10))
		&& !beyond_s3;

endmodule

// ----- hdl/segment_box_visibility_check_core.sv -----
// ----------------------------------------------------------------------------
// segment_box_visibility_check_core
// Line-of-sight check of a link segment against a table of 2-D boxes.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Every item gives one
// result, shown for one cycle with done high; the receiver cannot stall it.
// An add, and a query against an empty table, finish without raising busy:
// the result follows on the next cycle and another item may be taken at once.
// A query over N stored boxes holds busy while the boxes stream out of the
// edge RAMs one per cycle through a three-stage box test. The scan stops at
// the first box that blocks or after the last one, and the result is shown
// in the cycle in which busy falls.
module segment_box_visibility_check_core #(
	parameter int MAX_BOXES = sbvc_pkg::MAX_BOXES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 req_type,
	input  logic signed [sbvc_pkg::COORD_W-1:0]  box_x_min,
	input  logic signed [sbvc_pkg::COORD_W-1:0]  box_x_max,
	input  logic signed [sbvc_pkg::COORD_W-1:0]  box_y_min,
	input  logic signed [sbvc_pkg::COORD_W-1:0]  box_y_max,
	input  logic signed [sbvc_pkg::COORD_W-1:0]  end_a_x,
	input  logic signed [sbvc_pkg::COORD_W-1:0]  end_a_y,
	input  logic signed [sbvc_pkg::COORD_W-1:0]  end_b_x,
	input  logic signed [sbvc_pkg::COORD_W-1:0]  end_b_y,
	output logic                                 done,
	output logic                                 clear_sight,
	output logic [sbvc_pkg::INDEX_OUT_W-1:0]     blocker_index,
	output logic                                 status,
	output logic [sbvc_pkg::COUNT_OUT_W-1:0]     box_count
);

	localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CNT_W = $clog2(MAX_BOXES + 1);
	localparam int IW = sbvc_pkg::INDEX_OUT_W;
	localparam int OW = sbvc_pkg::COUNT_OUT_W;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic                 state_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     iss_q;
	sbvc_pkg::link_t      link_q;

	sbvc_pkg::ctl_t       ctl_s1;
	logic [AW-1:0]        idx_s1;
	sbvc_pkg::ctl_t       ctl_s3;
	logic [AW-1:0]        idx_s3;
	logic                 block_s3;

	logic [sbvc_pkg::EDGE_WORD_W-1:0] x_word_s1, y_word_s1;

	logic                 accept, is_add, is_query, full;
	logic                 issue, last_issue;
	logic                 hit, finish;

	logic [CNT_W+OW-1:0]  count_ext;
	logic [AW+IW-1:0]     idx_ext;

	assign busy       = (state_q == ST_SCAN);
	assign accept     = start && !busy;
	assign is_add     = accept && (req_type == sbvc_pkg::REQ_ADD);
	assign is_query   = accept && (req_type == sbvc_pkg::REQ_QUERY);
	assign full       = (count_q == CNT_W'(MAX_BOXES));

	assign hit        = ctl_s3.valid && block_s3;
	assign finish     = busy && ctl_s3.valid && (block_s3 || ctl_s3.last);
	assign issue      = busy && (iss_q != count_q) && !finish;
	assign last_issue = (CNT_W'(iss_q + 1'b1) == count_q);

	assign count_ext  = {{OW{1'b0}}, count_q};
	assign idx_ext    = {{IW{1'b0}}, idx_s3};

	sbvc_ram #(
		.WIDTH (sbvc_pkg::EDGE_WORD_W),
		.DEPTH (MAX_BOXES)
	) u_x_ram (
		.clk   (clk),
		.we    (is_add && !full),
		.waddr (count_q[AW-1:0]),
		.wdata ({box_x_max, box_x_min}),
		.raddr (iss_q[AW-1:0]),
		.rdata (x_word_s1)
	);

	sbvc_ram #(
		.WIDTH (sbvc_pkg::EDGE_WORD_W),
		.DEPTH (MAX_BOXES)
	) u_y_ram (
		.clk   (clk),
		.we    (is_add && !full),
		.waddr (count_q[AW-1:0]),
		.wdata ({box_y_max, box_y_min}),
		.raddr (iss_q[AW-1:0]),
		.rdata (y_word_s1)
	);

	sbvc_box_eval #(
		.MAX_BOXES (MAX_BOXES)
	) u_box_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.flush     (finish),
		.link      (link_q),
		.ctl_s1    (ctl_s1),
		.idx_s1    (idx_s1),
		.x_word_s1 (x_word_s1),
		.y_word_s1 (y_word_s1),
		.ctl_s3    (ctl_s3),
		.idx_s3    (idx_s3),
		.block_s3  (block_s3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			iss_q   <= '0;
			ctl_s1  <= '0;
			done    <= 1'b0;
		end else begin
			done   <= finish || is_add || (is_query && count_q == '0);
			ctl_s1 <= '{valid: issue && !finish, last: last_issue};
			if (is_query) begin
				iss_q <= '0;
			end else if (issue) begin
				iss_q <= CNT_W'(iss_q + 1'b1);
			end
			priority if (finish) begin
				state_q <= ST_IDLE;
			end else if (is_add) begin
				if (!full) begin
					count_q <= CNT_W'(count_q + 1'b1);
				end
			end else if (is_query) begin
				if (count_q != '0) begin
					state_q <= ST_SCAN;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= iss_q[AW-1:0];
		if (is_query) begin
			link_q.ax  <= end_a_x;
			link_q.ay  <= end_a_y;
			link_q.bx  <= end_b_x;
			link_q.by  <= end_b_y;
			link_q.dx  <= {end_b_x[sbvc_pkg::COORD_W-1], end_b_x}
				- {end_a_x[sbvc_pkg::COORD_W-1], end_a_x};
			link_q.dy  <= {end_b_y[sbvc_pkg::COORD_W-1], end_b_y}
				- {end_a_y[sbvc_pkg::COORD_W-1], end_a_y};
			link_q.neg <= (end_b_x < end_a_x);
		end
		priority if (finish) begin
			clear_sight   <= !hit;
			blocker_index <= hit ? idx_ext[IW-1:0] : '0;
			status        <= sbvc_pkg::STATUS_OK;
			box_count     <= count_ext[OW-1:0];
		end else if (is_add) begin
			clear_sight   <= 1'b0;
			blocker_index <= '0;
			status        <= full ? sbvc_pkg::STATUS_FULL : sbvc_pkg::STATUS_OK;
			box_count     <= full ? count_ext[OW-1:0]
				: OW'(count_ext[OW-1:0] + 1'b1);
		end else if (is_query) begin
			clear_sight   <= 1'b1;
			blocker_index <= '0;
			status        <= sbvc_pkg::STATUS_OK;
			box_count     <= count_ext[OW-1:0];
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_BOXES))
		else $error("box count beyond table depth");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while scan still running");

	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		is_add && !full |=> count_q == CNT_W'($past(count_q) + 1'b1))
		else $error("accepted add did not grow the table");

	a_refused_add: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == sbvc_pkg::STATUS_FULL |-> !clear_sight && blocker_index == '0)
		else $error("refused add reported a sight result");
`endif

endmodule
